@@ design/hptc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the humidity/pressure/temperature compensation unit.
// No dependencies.
package hptc_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    RegCalTemp,
    RegCalPressA,
    RegCalPressB,
    RegCalMixed,
    RegCalHumB
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
  } hptc_in_t;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic [24:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
  } hptc_out_t;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  // pressure divider: 64-bit dividend, divisor magnitude at most 2^30
  localparam int unsigned DivW      = 64;
  localparam int unsigned DivRemW   = 31;
  localparam int unsigned DivBits   = 4;
  localparam int unsigned DivStages = DivW / DivBits;

  typedef struct packed {
    logic [DivRemW-1:0] rem;
    logic [DivW-1:0]    dq;    // dividend bits shift out, quotient bits shift in
    logic [DivRemW-1:0] mb;
    logic               neg;
    logic               zero;
  } hptc_div_t;

endpackage

@@ design/humidity_pressure_temp_compensation_unit.sv @@
`timescale 1ns / 1ps
// Top level: pipelined integer compensation of raw temperature, pressure and humidity.
// Depends on hptc_pkg.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  hptc_in_t   in_data_i
//   out      source     out_valid_o/out_stall_i hptc_out_t out_data_o
//   cfg      sink       cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// One request per cycle is accepted while the output is not stalled; the pipeline is the pressure divider
// (16 stages of 4 quotient bits each) plus ten stages ahead of it and seven behind.
// Reset clears the calibration registers and all stage valid bits.
// A stalled result freezes the whole pipeline; nothing moves until it is taken.
module humidity_pressure_temp_compensation_unit
  import hptc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hptc_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hptc_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned StDivIn = 10;
  localparam int unsigned StQ     = StDivIn + DivStages + 1;
  localparam int unsigned StLast  = StQ + 6;

  localparam logic signed [19:0] TempHi     = 20'sd32767;
  localparam logic signed [19:0] TempLo     = -20'sd32768;
  localparam logic [31:0]        HumClamp   = 32'd419430400;
  localparam logic [16:0]        HumOutMax  = 17'd102400;
  localparam logic [63:0]        PressMax   = 64'h0000_0000_01FF_FFFF;

  function automatic logic [31:0] mul_lo32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] pr;
    pr = a * b;
    return pr[31:0];
  endfunction

  function automatic hptc_div_t div_step(input hptc_div_t cur);
    hptc_div_t          nxt;
    logic [DivRemW-1:0] r;
    nxt = cur;
    for (int i = 0; i < DivBits; i++) begin
      r = {nxt.rem[DivRemW-2:0], nxt.dq[DivW-1]};
      nxt.dq = {nxt.dq[DivW-2:0], 1'b0};
      if (r >= nxt.mb) begin
        r = r - nxt.mb;
        nxt.dq[0] = 1'b1;
      end
      nxt.rem = r;
    end
    return nxt;
  endfunction

  // ---------------- calibration registers ----------------
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q;
  logic [63:0] cal_press_b_q;
  logic [47:0] cal_mixed_q;
  logic [39:0] cal_hum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_mixed_q   <= '0;
      cal_hum_b_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegCalTemp:   cal_temp_q    <= cfg_wdata_i[47:0];
        RegCalPressA: cal_press_a_q <= cfg_wdata_i;
        RegCalPressB: cal_press_b_q <= cfg_wdata_i;
        RegCalMixed:  cal_mixed_q   <= cfg_wdata_i[47:0];
        RegCalHumB:   cal_hum_b_q   <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic [7:0]         h1, h3;
  logic signed [7:0]  h6;

  assign t1 = cal_temp_q[15:0];
  assign t2 = cal_temp_q[31:16];
  assign t3 = cal_temp_q[47:32];
  assign p1 = cal_press_a_q[15:0];
  assign p2 = cal_press_a_q[31:16];
  assign p3 = cal_press_a_q[47:32];
  assign p4 = cal_press_a_q[63:48];
  assign p5 = cal_press_b_q[15:0];
  assign p6 = cal_press_b_q[31:16];
  assign p7 = cal_press_b_q[47:32];
  assign p8 = cal_press_b_q[63:48];
  assign p9 = cal_mixed_q[15:0];
  assign h1 = cal_mixed_q[23:16];
  assign h2 = cal_mixed_q[39:24];
  assign h3 = cal_mixed_q[47:40];
  assign h4 = cal_hum_b_q[15:0];
  assign h5 = cal_hum_b_q[31:16];
  assign h6 = cal_hum_b_q[39:32];

  // ---------------- flow control ----------------
  logic [StLast:1] vld_q;
  logic            en;

  assign en          = !vld_q[StLast] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[StLast];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[StLast-1:1], in_valid_i};
    end
  end

  // ---------------- stage registers ----------------
  logic [19:0]        ap_q [1:7];
  logic [15:0]        ah_q [1:4];
  logic signed [15:0] tc_q [4:StLast];
  logic [16:0]        hum_q [StDivIn:StLast];
  logic [63:0]        p_q [StQ:StQ+4];
  logic               zero_q [StQ:StLast-1];

  logic signed [33:0] s1_d1t2_q;
  logic [31:0]        s1_d2sq_q;
  logic signed [22:0] s2_ta_q;
  logic signed [36:0] s2_tb_q;
  logic signed [23:0] s3_tf_q;
  logic signed [49:0] s4_xx_q;
  logic signed [40:0] s4_xp5_q, s4_xp2_q;
  logic [31:0]        s4_vh5_q, s4_vh6_q, s4_vh3_q;
  logic signed [16:0] s5_a_q, s6_a_q;
  logic [31:0]        s5_m_q, s6_b_q;
  logic signed [48:0] s5_lo6_q, s5_lo3_q;
  logic [31:0]        s5_hi6_q, s5_hi3_q;
  logic [63:0]        s5_c2_q, s5_c1_q, s6_c2_q, s6_c1_q;
  logic [63:0]        s6_xxp6_q, s6_xxp3_q;
  logic [63:0]        s7_w2_q, s7_w1a_q;
  logic [31:0]        s7_ab_q, s8_ab_q, s9_ab_q;
  logic [47:0]        s8_lo1_q;
  logic [31:0]        s8_hi1_q;
  logic [63:0]        s8_t_q;
  logic [31:0]        s8_ss_q, s9_sh_q;
  logic signed [30:0] s9_w1_q;
  logic [63:0]        s9_num_q;
  hptc_div_t          div_q [0:DivStages];
  logic [63:0]        sq_slsl_q;
  logic [31:0]        sq_shsl_q;
  logic signed [48:0] sq_lo8_q;
  logic [31:0]        sq_hi8_q;
  logic [63:0]        ss_q;
  logic signed [44:0] e2_q [StQ+2:StQ+4];
  logic signed [48:0] e1_lo_q;
  logic [31:0]        e1_hi_q;
  logic signed [38:0] e1_q;
  logic [63:0]        psum_q;
  logic [24:0]        press_q;

  // ---------------- combinational terms ----------------
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] d2sq;
  logic signed [27:0] tcm;
  logic signed [19:0] tcs;
  logic signed [15:0] tc_d;
  logic signed [24:0] x, hv;
  logic signed [40:0] hv5;
  logic signed [32:0] hv6;
  logic signed [33:0] hv3;
  logic [31:0]        a32, m1, m2, b0, bs, s8in, vf;
  logic signed [33:0] hi6w, hi3w;
  logic [63:0]        w1a_d, sum1, t_d, ma_d, q_d, p28, e2sum, e1sum, pf;
  logic [20:0]        pp21;
  logic [30:0]        mb_d;
  logic [16:0]        hum_d;
  logic [24:0]        press_d;

  assign d1   = $signed({1'b0, in_data_i.adc_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2   = $signed({1'b0, in_data_i.adc_temp[19:4]}) - $signed({1'b0, t1});
  assign d2sq = d2 * d2;

  assign tcm = s3_tf_q * 28'sd5 + 28'sd128;
  assign tcs = tcm[27:8];
  always_comb begin
    priority if (tcs > TempHi) tc_d = TempHi[15:0];
    else if (tcs < TempLo)     tc_d = TempLo[15:0];
    else                       tc_d = tcs[15:0];
  end

  assign x   = s3_tf_q - 25'sd128000;
  assign hv  = s3_tf_q - 25'sd76800;
  assign hv5 = hv * h5;
  assign hv6 = hv * h6;
  assign hv3 = hv * $signed({1'b0, h3});

  assign a32  = {2'b00, ah_q[4], 14'd0} - {h4[11:0], 20'd0} - s4_vh5_q + 32'd16384;
  assign m1   = {{10{s4_vh6_q[31]}}, s4_vh6_q[31:10]};
  assign m2   = {{11{s4_vh3_q[31]}}, s4_vh3_q[31:11]} + 32'd32768;
  assign hi6w = $signed(s4_xx_q[49:32]) * p6;
  assign hi3w = $signed(s4_xx_q[49:32]) * p3;

  assign b0 = {{10{s5_m_q[31]}}, s5_m_q[31:10]} + 32'd2097152;
  assign bs = s6_b_q + 32'd8192;

  assign w1a_d = {{8{s6_xxp3_q[63]}}, s6_xxp3_q[63:8]} + s6_c1_q + (64'd1 << 47);
  assign pp21  = 21'd1048576 - {1'b0, ap_q[7]};
  assign t_d   = ({43'd0, pp21} << 31) - s7_w2_q;
  assign s8in  = {{15{s7_ab_q[31]}}, s7_ab_q[31:15]};

  assign sum1 = {16'd0, s8_lo1_q} + {s8_hi1_q, 32'd0};

  assign ma_d = s9_num_q[63] ? (64'd0 - s9_num_q) : s9_num_q;
  assign mb_d = s9_w1_q[30] ? (31'd0 - s9_w1_q) : s9_w1_q;
  assign vf   = s9_ab_q - {{4{s9_sh_q[31]}}, s9_sh_q[31:4]};
  always_comb begin
    priority if (vf[31])   hum_d = '0;
    else if (vf > HumClamp) hum_d = HumOutMax;
    else                    hum_d = vf[28:12];
  end

  assign q_d   = div_q[DivStages].neg ? (64'd0 - div_q[DivStages].dq) : div_q[DivStages].dq;
  assign p28   = p_q[StQ];
  assign e2sum = {{15{sq_lo8_q[48]}}, sq_lo8_q} + {sq_hi8_q, 32'd0};
  assign e1sum = {{15{e1_lo_q[48]}}, e1_lo_q} + {e1_hi_q, 32'd0};

  assign pf = {{8{psum_q[63]}}, psum_q[63:8]} + ({{48{p7[15]}}, p7} << 4);
  always_comb begin
    priority if (zero_q[StLast-1]) press_d = '0;
    else if (pf[63])               press_d = '0;
    else if (pf > PressMax)        press_d = PressMax[24:0];
    else                           press_d = pf[24:0];
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      // temperature
      s1_d1t2_q <= d1 * t2;
      s1_d2sq_q <= d2sq[31:0];
      ap_q[1]   <= in_data_i.adc_press;
      ah_q[1]   <= in_data_i.adc_hum;
      for (int k = 2; k <= 7; k++) ap_q[k] <= ap_q[k-1];
      for (int k = 2; k <= 4; k++) ah_q[k] <= ah_q[k-1];
      s2_ta_q <= s1_d1t2_q[33:11];
      s2_tb_q <= $signed({1'b0, s1_d2sq_q[31:12]}) * t3;
      s3_tf_q <= s2_ta_q + $signed(s2_tb_q[36:14]);
      tc_q[4] <= tc_d;
      for (int k = 5; k <= StLast; k++) tc_q[k] <= tc_q[k-1];

      // first products off the fine temperature
      s4_xx_q  <= x * x;
      s4_xp5_q <= x * p5;
      s4_xp2_q <= x * p2;
      s4_vh5_q <= hv5[31:0];
      s4_vh6_q <= hv6[31:0];
      s4_vh3_q <= hv3[31:0];

      // humidity, 32-bit wrapping
      s5_a_q  <= a32[31:15];
      s5_m_q  <= mul_lo32(m1, m2);
      s6_a_q  <= s5_a_q;
      s6_b_q  <= mul_lo32(b0, {{16{h2[15]}}, h2});
      s7_ab_q <= mul_lo32({{15{s6_a_q[16]}}, s6_a_q}, {{14{bs[31]}}, bs[31:14]});
      s8_ab_q <= s7_ab_q;
      s8_ss_q <= mul_lo32(s8in, s8in);
      s9_ab_q <= s8_ab_q;
      s9_sh_q <= mul_lo32({{7{s8_ss_q[31]}}, s8_ss_q[31:7]}, {24'd0, h1});
      hum_q[StDivIn] <= hum_d;
      for (int k = StDivIn + 1; k <= StLast; k++) hum_q[k] <= hum_q[k-1];

      // pressure ahead of the divider, 64-bit wrapping
      s5_lo6_q  <= $signed({1'b0, s4_xx_q[31:0]}) * p6;
      s5_lo3_q  <= $signed({1'b0, s4_xx_q[31:0]}) * p3;
      s5_hi6_q  <= hi6w[31:0];
      s5_hi3_q  <= hi3w[31:0];
      s5_c2_q   <= ({{23{s4_xp5_q[40]}}, s4_xp5_q} << 17) + ({{48{p4[15]}}, p4} << 35);
      s5_c1_q   <= {{23{s4_xp2_q[40]}}, s4_xp2_q} << 12;
      s6_xxp6_q <= {{15{s5_lo6_q[48]}}, s5_lo6_q} + {s5_hi6_q, 32'd0};
      s6_xxp3_q <= {{15{s5_lo3_q[48]}}, s5_lo3_q} + {s5_hi3_q, 32'd0};
      s6_c2_q   <= s5_c2_q;
      s6_c1_q   <= s5_c1_q;
      s7_w2_q   <= s6_xxp6_q + s6_c2_q;
      s7_w1a_q  <= w1a_d;
      s8_lo1_q  <= s7_w1a_q[31:0] * p1;
      s8_hi1_q  <= mul_lo32(s7_w1a_q[63:32], {16'd0, p1});
      s8_t_q    <= t_d;
      s9_w1_q   <= sum1[63:33];
      s9_num_q  <= s8_t_q * 64'd3125;
      div_q[0]  <= '{rem: '0, dq: ma_d, mb: mb_d,
                     neg: s9_num_q[63] ^ s9_w1_q[30], zero: (s9_w1_q == '0)};

      // behind the divider
      p_q[StQ]    <= q_d;
      zero_q[StQ] <= div_q[DivStages].zero;
      for (int k = StQ + 1; k <= StQ + 4; k++) p_q[k] <= p_q[k-1];
      for (int k = StQ + 1; k <= StLast - 1; k++) zero_q[k] <= zero_q[k-1];

      // (p >>> 13)^2 mod 2^64 from a low square and a doubled cross term
      sq_slsl_q <= p28[44:13] * p28[44:13];
      sq_shsl_q <= mul_lo32({{13{p28[63]}}, p28[63:45]}, p28[44:13]);
      sq_lo8_q  <= $signed({1'b0, p28[31:0]}) * p8;
      sq_hi8_q  <= mul_lo32(p28[63:32], {{16{p8[15]}}, p8});
      ss_q      <= sq_slsl_q + {sq_shsl_q[30:0], 33'd0};
      e2_q[StQ+2] <= e2sum[63:19];
      for (int k = StQ + 3; k <= StQ + 4; k++) e2_q[k] <= e2_q[k-1];
      e1_lo_q   <= $signed({1'b0, ss_q[31:0]}) * p9;
      e1_hi_q   <= mul_lo32(ss_q[63:32], {{16{p9[15]}}, p9});
      e1_q      <= e1sum[63:25];
      psum_q    <= p_q[StQ+4] + {{25{e1_q[38]}}, e1_q} + {{19{e2_q[StQ+4][44]}}, e2_q[StQ+4]};
      press_q   <= press_d;
    end
  end

  for (genvar g = 1; g <= DivStages; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[g] <= div_step(div_q[g-1]);
      end
    end
  end

  assign out_data_o = '{temp_centi:  tc_q[StLast],
                        press_q24_8: press_q,
                        hum_q22_10:  hum_q[StLast]};

  // ---------------- assertions ----------------
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("held result did not stall the input");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> (out_valid_o == $past(vld_q[StLast-1])))
    else $error("valid lost or invented on advance");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[StQ-1] && !div_q[DivStages].zero) |-> (div_q[DivStages].rem < div_q[DivStages].mb))
    else $error("divider remainder not below divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hum_q22_10 <= HumOutMax))
    else $error("humidity beyond clamp");

endmodule
